// File: rtl/gad_pkg.sv
// ----------------------------------------------------------------------------
// gad_pkg
// Shared constants, types and helpers of the gray downscaler with 1-bit dither.
// ----------------------------------------------------------------------------
package gad_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 3072;
    localparam int ERR_DEPTH  = MAX_WIDTH + 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ERR_AW     = $clog2(ERR_DEPTH);
    localparam int SUM_W      = 20;
    localparam int DIM_W      = 12;
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam logic [DIM_W-1:0] COUNT_MAX = '1;

    localparam logic [2:0] CFG_SRC_W = 3'd0;
    localparam logic [2:0] CFG_SRC_H = 3'd1;
    localparam logic [2:0] CFG_TGT_W = 3'd2;
    localparam logic [2:0] CFG_TGT_H = 3'd3;

    localparam logic [3:0] DIV_BITS_PIX = 4'd8;
    localparam logic [3:0] DIV_BITS_ROW = 4'd12;

    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [11:0] divisor;
        logic [3:0]  nbits;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [11:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ACC, ST_DIVA, ST_WAITA, ST_DIVB, ST_WAITB,
        ST_W_INIT, ST_W_RD, ST_W_SDIV, ST_W_SWAIT, ST_W_AVG, ST_W_AWAIT,
        ST_W_DITH, ST_W_TAIL0, ST_W_TAIL1
    } t_state;

    // divide by 16, truncating toward zero
    function automatic logic signed [8:0] trunc16(input logic signed [11:0] v);
        logic signed [11:0] a;
        a = v[11] ? -v : v;
        a = a >>> 4;
        return v[11] ? 9'(-a) : 9'(a);
    endfunction

endpackage

// File: rtl/gad_ram.sv
// ----------------------------------------------------------------------------
// gad_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

// File: rtl/gad_div.sv
// ----------------------------------------------------------------------------
// gad_div
// Restoring divider, one quotient bit a cycle, saturating to the bit count.
// ----------------------------------------------------------------------------
module gad_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gad_pkg::t_div_req  i_req,
    output gad_pkg::t_div_rsp  o_rsp
);
    import gad_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [23:0] r_rem, n_rem;
    logic [11:0] r_quot, n_quot;
    logic [11:0] r_dvs, n_dvs;
    logic [3:0]  r_k, n_k;
    logic [23:0] shifted;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_dvs   = r_dvs;
        n_k     = r_k;
        shifted = {12'd0, r_dvs} << r_k;
        if (i_req.start) begin
            n_dvs = i_req.divisor;
            if ({1'b0, i_req.dividend} >= ({13'd0, i_req.divisor} << i_req.nbits)) begin
                n_quot = 12'((13'd1 << i_req.nbits) - 13'd1);
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_quot = '0;
                n_rem  = i_req.dividend;
                n_k    = i_req.nbits - 4'd1;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            if (r_rem >= shifted) begin
                n_rem        = r_rem - shifted;
                n_quot[r_k]  = 1'b1;
            end
            if (r_k == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_k = r_k - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_dvs  <= n_dvs;
        r_k    <= n_k;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
endmodule

// File: rtl/gray_area_downscale_dither_1bpp.sv
// ----------------------------------------------------------------------------
// gray_area_downscale_dither_1bpp
// Area-average gray downscaler with 1-bit Floyd-Steinberg dither, packed out.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one per transaction, and each takes a read
// and a write-back of its column sum in the sum memory. At the end of each
// source row that does not end the image, two 12-step divisions decide
// whether the target row is complete. Finishing a target row walks the sum
// memory once: a per-column divide by the row count for each source column,
// plus a segment average and dither for each target column, all on the
// shared one-bit-a-cycle divider. Words leave through an output register, so
// the next pixel is taken while the last word still waits. No clearing pass
// is needed: a fill count marks the valid column sums and an extent register
// marks the valid entries of the error memory, both dropped to zero after
// reset and at image end.
// ----------------------------------------------------------------------------
module gray_area_downscale_dither_1bpp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_gray,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_packed_word,
    output logic        o_last_in_row,
    output logic        o_last_in_image
);
    import gad_pkg::*;

    // configuration, held raw and clamped on use
    logic [11:0] r_src_w, r_src_h, r_tgt_w, r_tgt_h;
    logic [11:0] sw, sh, tw, th, swm1, shm1;

    t_state r_state, n_state;

    logic [COL_W-1:0]  r_src_col, n_src_col, r_col, n_col;
    logic [11:0]       r_src_row, n_src_row, r_row, n_row;
    logic [11:0]       r_rows, n_rows, r_cnt, n_cnt, r_ext, n_ext;
    logic [7:0]        r_gray, n_gray, r_avg, n_avg;
    logic              r_last_img, n_last_img;
    logic [23:0]       r_prod, n_prod;
    logic [11:0]       r_qa, n_qa, r_x, n_x, r_n, n_n;
    logic [COL_W-1:0]  r_i, n_i;
    logic signed [12:0] r_d, n_d, d_step;
    logic [18:0]       r_segsum, n_segsum;
    logic signed [8:0] r_carry, n_carry, r_na, n_na, r_nb, n_nb;
    logic [31:0]       r_word, n_word;
    logic              r_out_valid, n_out_valid, r_out_lrow, n_out_lrow;
    logic              r_out_limg, n_out_limg;
    logic [31:0]       r_out_word, n_out_word;

    // memories
    logic             sum_we, sum_re, err_we, err_re;
    logic [COL_W-1:0] sum_waddr, sum_raddr;
    logic [SUM_W-1:0] sum_wdata, sum_rdata;
    logic [ERR_AW-1:0] err_waddr, err_raddr;
    logic [8:0]       err_wdata, err_rdata;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // scratch
    logic [COL_W-1:0] colc;
    logic [11:0]      rowc, i_p1;
    logic [SUM_W-1:0] old_sum;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] walk_sum;
    logic signed [10:0] ev, g;
    logic [8:0]       gc;
    logic signed [8:0] e;
    logic signed [11:0] e12;
    logic             white, last_i, push, out_free;

    gad_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_sum_ram (
        .i_clk  (i_clk),
        .i_we   (sum_we),
        .i_waddr(sum_waddr),
        .i_wdata(sum_wdata),
        .i_re   (sum_re),
        .i_raddr(sum_raddr),
        .o_rdata(sum_rdata)
    );

    gad_ram #(.WIDTH(9), .DEPTH(ERR_DEPTH)) u_err_ram (
        .i_clk  (i_clk),
        .i_we   (err_we),
        .i_waddr(err_waddr),
        .i_wdata(err_wdata),
        .i_re   (err_re),
        .i_raddr(err_raddr),
        .o_rdata(err_rdata)
    );

    gad_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // clamp the dimensions; a zero acts as one
    always_comb begin
        sw = (r_src_w == 12'd0) ? 12'd1 :
             (r_src_w > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : r_src_w;
        sh = (r_src_h == 12'd0) ? 12'd1 :
             (r_src_h > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : r_src_h;
        tw = (r_tgt_w == 12'd0) ? 12'd1 : (r_tgt_w > sw) ? sw : r_tgt_w;
        th = (r_tgt_h == 12'd0) ? 12'd1 : (r_tgt_h > sh) ? sh : r_tgt_h;
        swm1 = sw - 12'd1;
        shm1 = sh - 12'd1;
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= 12'd1;
            r_src_h <= 12'd1;
            r_tgt_w <= 12'd1;
            r_tgt_h <= 12'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_W: r_src_w <= i_cfg_data;
                CFG_SRC_H: r_src_h <= i_cfg_data;
                CFG_TGT_W: r_tgt_w <= i_cfg_data;
                CFG_TGT_H: r_tgt_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        n_src_col  = r_src_col;
        n_src_row  = r_src_row;
        n_col      = r_col;
        n_row      = r_row;
        n_rows     = r_rows;
        n_cnt      = r_cnt;
        n_ext      = r_ext;
        n_gray     = r_gray;
        n_avg      = r_avg;
        n_last_img = r_last_img;
        n_prod     = r_prod;
        n_qa       = r_qa;
        n_x        = r_x;
        n_n        = r_n;
        n_i        = r_i;
        n_d        = r_d;
        n_segsum   = r_segsum;
        n_carry    = r_carry;
        n_na       = r_na;
        n_nb       = r_nb;
        n_word     = r_word;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word = r_out_word;
        n_out_lrow = r_out_lrow;
        n_out_limg = r_out_limg;

        sum_we = 1'b0;  sum_waddr = r_col;  sum_wdata = '0;
        sum_re = 1'b0;  sum_raddr = r_x[COL_W-1:0];
        err_we = 1'b0;  err_waddr = ERR_AW'(r_i);  err_wdata = '0;
        i_p1   = {1'b0, r_i} + 12'd1;
        err_re = 1'b0;  err_raddr = i_p1;

        div_req.start    = 1'b0;
        div_req.dividend = {5'd0, r_segsum};
        div_req.divisor  = r_n;
        div_req.nbits    = DIV_BITS_PIX;

        colc = ({1'b0, r_src_col} > swm1) ? swm1[COL_W-1:0] : r_src_col;
        rowc = (r_src_row > shm1) ? shm1 : r_src_row;
        old_sum  = ({1'b0, r_col} < r_cnt) ? sum_rdata : '0;
        sum_add  = {1'b0, old_sum} + {13'd0, r_gray};
        walk_sum = (r_x < r_cnt) ? sum_rdata : '0;
        d_step   = r_d - $signed({1'b0, tw});

        ev    = (i_p1 < r_ext) ? 11'($signed(err_rdata)) : 11'sd0;
        g     = $signed({3'd0, r_avg}) + ev + 11'(r_carry);
        gc    = g[10] ? 9'd0 : (g > 11'sd255) ? 9'd255 : g[8:0];
        white = (gc >= 9'd128);
        e     = white ? $signed(gc - 9'd255) : $signed(gc);
        e12   = 12'(e);
        last_i = ({1'b0, r_i} == (tw - 12'd1));
        push   = (r_i[4:0] == 5'd31) || last_i;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    // image start: drop sums, row count and error rows
                    if (r_src_row == 12'd0 && r_src_col == '0) begin
                        n_cnt  = '0;
                        n_rows = '0;
                        n_ext  = '0;
                    end
                    n_gray = i_gray;
                    n_col  = colc;
                    n_row  = rowc;
                    sum_re = 1'b1;
                    sum_raddr = colc;
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                sum_we    = 1'b1;
                sum_wdata = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                if ({1'b0, r_col} >= r_cnt) begin
                    n_cnt = {1'b0, r_col} + 12'd1;
                end
                if ({1'b0, r_col} < swm1) begin
                    n_src_col = r_col + 1'b1;
                    n_state   = ST_IDLE;
                end else begin
                    n_src_col  = '0;
                    n_rows     = (r_rows < COUNT_MAX) ? r_rows + 12'd1 : r_rows;
                    n_last_img = (r_row >= shm1);
                    n_src_row  = (r_row >= shm1) ? 12'd0 : r_row + 12'd1;
                    n_prod     = r_row * th;
                    n_state    = (r_row >= shm1) ? ST_W_INIT : ST_DIVA;
                end
            end
            ST_DIVA: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod;
                div_req.divisor  = sh;
                div_req.nbits    = DIV_BITS_ROW;
                n_state = ST_WAITA;
            end
            ST_WAITA: begin
                if (div_rsp.done) begin
                    n_qa    = div_rsp.quot;
                    n_state = ST_DIVB;
                end
            end
            ST_DIVB: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod + {12'd0, th};
                div_req.divisor  = sh;
                div_req.nbits    = DIV_BITS_ROW;
                n_state = ST_WAITB;
            end
            ST_WAITB: begin
                if (div_rsp.done) begin
                    n_state = (div_rsp.quot != r_qa) ? ST_W_INIT : ST_IDLE;
                end
            end
            ST_W_INIT: begin
                n_x      = '0;
                n_i      = '0;
                n_d      = $signed({1'b0, sw}) - $signed({1'b0, tw});
                n_segsum = '0;
                n_n      = '0;
                n_carry  = '0;
                n_na     = '0;
                n_nb     = '0;
                n_word   = '0;
                n_state  = ST_W_RD;
            end
            ST_W_RD: begin
                sum_re  = 1'b1;
                n_state = ST_W_SDIV;
            end
            ST_W_SDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = {4'd0, walk_sum};
                div_req.divisor  = r_rows;
                n_state = ST_W_SWAIT;
            end
            ST_W_SWAIT: begin
                if (div_rsp.done) begin
                    n_segsum = r_segsum + {11'd0, div_rsp.quot[7:0]};
                    n_n      = r_n + 12'd1;
                    n_x      = r_x + 12'd1;
                    // advance to the next target column when the segment ends
                    if (d_step < 0) begin
                        n_d     = d_step + $signed({1'b0, sw});
                        n_state = ST_W_AVG;
                    end else begin
                        n_d     = d_step;
                        n_state = ST_W_RD;
                    end
                end
            end
            ST_W_AVG: begin
                div_req.start = 1'b1;
                err_re  = 1'b1;
                n_state = ST_W_AWAIT;
            end
            ST_W_AWAIT: begin
                if (div_rsp.done) begin
                    n_avg   = div_rsp.quot[7:0];
                    n_state = ST_W_DITH;
                end
            end
            ST_W_DITH: begin
                if (!push || out_free) begin
                    err_we    = 1'b1;
                    err_wdata = r_na + trunc16(e12 * 12'sd3);
                    n_na      = r_nb + trunc16(e12 * 12'sd5);
                    n_nb      = trunc16(e12);
                    n_carry   = trunc16(e12 * 12'sd7);
                    n_word    = r_word | (32'(white) << (5'd31 - r_i[4:0]));
                    if (push) begin
                        n_out_valid = 1'b1;
                        n_out_word  = n_word;
                        n_out_lrow  = last_i;
                        n_out_limg  = last_i && r_last_img;
                        n_word      = '0;
                    end
                    n_segsum = '0;
                    n_n      = '0;
                    if (last_i) begin
                        n_state = ST_W_TAIL0;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_W_RD;
                    end
                end
            end
            ST_W_TAIL0: begin
                err_we    = 1'b1;
                err_waddr = ERR_AW'(tw);
                err_wdata = r_na;
                n_state   = ST_W_TAIL1;
            end
            ST_W_TAIL1: begin
                err_we    = 1'b1;
                err_waddr = ERR_AW'(tw + 12'd1);
                err_wdata = r_nb;
                // hand the next-row errors over as the current row; drop at image end
                n_ext   = r_last_img ? 12'd0 : tw + 12'd2;
                n_cnt   = '0;
                n_rows  = '0;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_src_col   <= '0;
            r_src_row   <= '0;
            r_rows      <= '0;
            r_cnt       <= '0;
            r_ext       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_src_col   <= n_src_col;
            r_src_row   <= n_src_row;
            r_rows      <= n_rows;
            r_cnt       <= n_cnt;
            r_ext       <= n_ext;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col      <= n_col;
        r_row      <= n_row;
        r_gray     <= n_gray;
        r_avg      <= n_avg;
        r_last_img <= n_last_img;
        r_prod     <= n_prod;
        r_qa       <= n_qa;
        r_x        <= n_x;
        r_n        <= n_n;
        r_i        <= n_i;
        r_d        <= n_d;
        r_segsum   <= n_segsum;
        r_carry    <= n_carry;
        r_na       <= n_na;
        r_nb       <= n_nb;
        r_word     <= n_word;
        r_out_word <= n_out_word;
        r_out_lrow <= n_out_lrow;
        r_out_limg <= n_out_limg;
    end

    assign o_out_valid     = r_out_valid;
    assign o_packed_word   = r_out_word;
    assign o_last_in_row   = r_out_lrow;
    assign o_last_in_image = r_out_limg;
endmodule
